>>> hdl/bucket_offset_table_top_macros.svh
// Assertion helpers for the bucket offset table.
`ifndef BUCKET_OFFSET_TABLE_TOP_MACROS_SVH
`define BUCKET_OFFSET_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BOT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BOT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bot_pkg.sv
`default_nettype none

package bot_pkg;

    localparam int NUM_ROWS     = 1024;
    localparam int ROW_DEPTH    = 16;
    localparam int OFFSET_WIDTH = 32;

    localparam int ROW_FIELD_W = 10;
    localparam int OFS_FIELD_W = 32;

    localparam int ROW_W   = $clog2(NUM_ROWS);
    localparam int DEPTH_W = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int FILL_W  = $clog2(ROW_DEPTH + 1);
    localparam int ENT_AW  = $clog2(NUM_ROWS * ROW_DEPTH);
    localparam int OFS_W   = (OFFSET_WIDTH < OFS_FIELD_W) ? OFFSET_WIDTH : OFS_FIELD_W;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic                   func;
        logic [ROW_FIELD_W-1:0] row;
        logic [OFS_FIELD_W-1:0] offset;
    } bot_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [FILL_W-1:0] fill_after;
    } bot_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_FINISH
    } bot_state_t;

    typedef struct packed {
        logic is_remove;
        logic row_full;
        logic row_empty;
        logic hit;
        logic scan_end;
        logic out_free;
    } bot_flags_t;

    typedef struct packed {
        bot_state_t       state;
        logic             in_ready;
        logic             clr_we;
        logic [ROW_W-1:0] clr_addr;
    } bot_ctrl_t;

    function automatic logic [ENT_AW-1:0] ent_addr(input logic [ROW_W-1:0] row,
                                                    input logic [DEPTH_W-1:0] idx);
        ent_addr = ENT_AW'(row) * ENT_AW'(ROW_DEPTH) + ENT_AW'(idx);
    endfunction

endpackage

`default_nettype wire

>>> hdl/bot_seq.sv
`default_nettype none

module bot_seq (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire bot_pkg::bot_flags_t flags,
    output bot_pkg::bot_ctrl_t      ctrl
);
    import bot_pkg::*;

    bot_state_t       state_reg, state_next;
    logic [ROW_W-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + ROW_W'(1);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == ROW_W'(NUM_ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (flags.is_remove && !flags.row_empty) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN: begin
                priority if (flags.hit) begin
                    state_next = ST_MOVE_RD;
                end else if (flags.scan_end) begin
                    state_next = ST_FINISH;
                end
            end
            ST_MOVE_RD: state_next = ST_MOVE_WR;
            ST_MOVE_WR: state_next = ST_FINISH;
            ST_FINISH: begin
                if (flags.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        ctrl.state    = state_reg;
        ctrl.in_ready = (state_reg == ST_IDLE);
        ctrl.clr_we   = (state_reg == ST_CLEAR);
        ctrl.clr_addr = clr_addr_reg;
    end

endmodule

`default_nettype wire

>>> hdl/bucket_offset_table_top.sv
`default_nettype none

// Table of NUM_ROWS rows, each holding up to ROW_DEPTH offsets with a fill count per
// row. Insert appends to the addressed row or reports full; remove finds the first
// equal offset, replaces it with the row's last entry and shrinks the row, or reports
// not found. One result beat per input beat. After reset the block clears all
// NUM_ROWS fill counts, one per cycle, before it takes its first beat. An insert
// passes through the FILL and FINISH states before the next beat can be accepted.
// A remove walks the row through the entry RAM's single read port and one offset
// comparator, one entry per cycle, in the SCAN state; on a match it reads the row's
// last entry and writes it over the match in MOVE_RD and MOVE_WR. A finished result
// waits in the output register while the next beat is accepted.
module bucket_offset_table_top (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire bot_pkg::bot_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output bot_pkg::bot_out_t     m_data
);
    import bot_pkg::*;

    `include "bucket_offset_table_top_macros.svh"

    logic [FILL_W-1:0] fill_mem [NUM_ROWS];
    logic [OFS_W-1:0]  ent_mem  [NUM_ROWS * ROW_DEPTH];

    bot_ctrl_t  ctrl;
    bot_flags_t flags;

    logic               req_func_reg;
    logic [ROW_W-1:0]   req_row_reg;
    logic [OFS_W-1:0]   req_ofs_reg;
    logic [FILL_W-1:0]  fill_rd_reg;
    logic [OFS_W-1:0]   ent_rd_reg;
    logic [DEPTH_W-1:0] scan_idx_reg;
    logic [1:0]         res_status_reg;
    logic [FILL_W-1:0]  res_fill_reg;
    logic               m_valid_reg;
    bot_out_t           m_data_reg;

    logic               accept;
    logic [FILL_W-1:0]  fill_cnt;
    logic [FILL_W-1:0]  fill_inc;
    logic [FILL_W-1:0]  fill_dec;
    logic [FILL_W-1:0]  scan_nxt;
    logic [DEPTH_W-1:0] ent_rd_idx;
    logic               ent_we;
    logic [DEPTH_W-1:0] ent_wr_idx;
    logic [OFS_W-1:0]   ent_wr_data;
    logic               fill_we;
    logic [ROW_W-1:0]   fill_wr_addr;
    logic [FILL_W-1:0]  fill_wr_data;
    logic               out_load;

    bot_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    assign s_ready = ctrl.in_ready;
    assign accept  = s_valid && ctrl.in_ready;

    assign fill_cnt = (fill_rd_reg > FILL_W'(ROW_DEPTH)) ? FILL_W'(ROW_DEPTH) : fill_rd_reg;
    assign fill_inc = fill_cnt + FILL_W'(1);
    assign fill_dec = fill_cnt - FILL_W'(1);
    assign scan_nxt = FILL_W'(scan_idx_reg) + FILL_W'(1);

    assign flags.is_remove = (req_func_reg == FUNC_REMOVE);
    assign flags.row_full  = (fill_cnt >= FILL_W'(ROW_DEPTH));
    assign flags.row_empty = (fill_cnt == '0);
    assign flags.hit       = (ent_rd_reg == req_ofs_reg);
    assign flags.scan_end  = (scan_nxt == fill_cnt);
    assign flags.out_free  = !m_valid_reg || m_ready;

    // Entry RAM read address: first entry on lookup, the next one while
    // scanning, the row's last entry before the move.
    always_comb begin
        unique case (ctrl.state)
            ST_FILL:    ent_rd_idx = '0;
            ST_SCAN:    ent_rd_idx = scan_nxt[DEPTH_W-1:0];
            ST_MOVE_RD: ent_rd_idx = fill_dec[DEPTH_W-1:0];
            default:    ent_rd_idx = '0;
        endcase
    end

    always_comb begin
        ent_we       = 1'b0;
        ent_wr_idx   = fill_cnt[DEPTH_W-1:0];
        ent_wr_data  = req_ofs_reg;
        fill_we      = 1'b0;
        fill_wr_addr = req_row_reg;
        fill_wr_data = fill_inc;
        unique case (ctrl.state)
            ST_CLEAR: begin
                fill_we      = ctrl.clr_we;
                fill_wr_addr = ctrl.clr_addr;
                fill_wr_data = '0;
            end
            ST_FILL: begin
                if (!flags.is_remove && !flags.row_full) begin
                    ent_we  = 1'b1;
                    fill_we = 1'b1;
                end
            end
            ST_MOVE_WR: begin
                // overwrite the matched entry with the row's last one
                ent_we       = 1'b1;
                ent_wr_idx   = scan_idx_reg;
                ent_wr_data  = ent_rd_reg;
                fill_we      = 1'b1;
                fill_wr_data = fill_dec;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (fill_we) begin
            fill_mem[fill_wr_addr] <= fill_wr_data;
        end
        if (accept) begin
            fill_rd_reg <= fill_mem[ROW_W'(s_data.row)];
        end
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_addr(req_row_reg, ent_wr_idx)] <= ent_wr_data;
        end
        ent_rd_reg <= ent_mem[ent_addr(req_row_reg, ent_rd_idx)];
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_func_reg <= s_data.func;
            req_row_reg  <= ROW_W'(s_data.row);
            req_ofs_reg  <= s_data.offset[OFS_W-1:0];
        end
        unique case (ctrl.state)
            ST_FILL: begin
                scan_idx_reg <= '0;
                priority if (flags.is_remove) begin
                    res_status_reg <= STATUS_NOT_FOUND;
                    res_fill_reg   <= fill_cnt;
                end else if (flags.row_full) begin
                    res_status_reg <= STATUS_FULL;
                    res_fill_reg   <= fill_cnt;
                end else begin
                    res_status_reg <= STATUS_DONE;
                    res_fill_reg   <= fill_inc;
                end
            end
            ST_SCAN: begin
                if (!flags.hit && !flags.scan_end) begin
                    scan_idx_reg <= scan_nxt[DEPTH_W-1:0];
                end
            end
            ST_MOVE_WR: begin
                res_status_reg <= STATUS_DONE;
                res_fill_reg   <= fill_dec;
            end
            default: begin
            end
        endcase
    end

    assign out_load = (ctrl.state == ST_FINISH) && flags.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.status     <= res_status_reg;
            m_data_reg.fill_after <= res_fill_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BOT_ASSERT_NEXT(a_one_item, aclk, aresetn, accept, !s_ready, "second beat taken mid-operation")
    `BOT_ASSERT_NOW(a_fill_bound, aclk, aresetn, m_valid, m_data.fill_after <= FILL_W'(ROW_DEPTH), "fill count out of range")
    `BOT_ASSERT_NOW(a_status_code, aclk, aresetn, m_valid, m_data.status == STATUS_DONE || m_data.status == STATUS_FULL || m_data.status == STATUS_NOT_FOUND, "bad status code")
    `BOT_ASSERT_NOW(a_move_nonempty, aclk, aresetn, ctrl.state == ST_MOVE_WR, fill_cnt != '0 && flags.is_remove, "move on empty row")

endmodule

`default_nettype wire

>>> sim/bucket_offset_table_top_tb.sv
`default_nettype none

module bucket_offset_table_top_tb;
    import bot_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 60;
    localparam int RUN_LIMIT    = 4000000;
    localparam int NUM_DIRECTED = 18;
    localparam int NUM_HOT_ROWS = 4;
    localparam int POOL_SIZE    = 8;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    typedef struct packed {
        logic                   func;
        logic [ROW_FIELD_W-1:0] row;
        logic [OFS_FIELD_W-1:0] offset;
        int                     reps;
        bit                     typed;
        logic [1:0]             status;
        logic [FILL_W-1:0]      fill;
    } dir_step_t;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    bot_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bot_out_t m_data;

    // Shadow copy of the table
    logic [FILL_W-1:0] table_fill [NUM_ROWS];
    logic [OFS_W-1:0]  table_ofs  [NUM_ROWS][ROW_DEPTH];

    bot_out_t expected_results[$];
    int       errors = 0;
    int       burst_left = 0;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_phase_left = 0;
    int       rx_count = 0;

    dir_step_t dir_steps [NUM_DIRECTED];

    bucket_offset_table_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #RUN_LIMIT;
        $display("FAIL");
        $finish;
    end

    // Apply one operation to the shadow table and return its result.
    function automatic bot_out_t apply_table_op(input bot_in_t item);
        int                r;
        int                fill;
        logic [OFS_W-1:0]  val;
        bit                found;
        bot_out_t          res;
        r     = int'(item.row) % NUM_ROWS;
        val   = item.offset[OFS_W-1:0];
        fill  = int'(table_fill[r]);
        found = 1'b0;
        if (fill > ROW_DEPTH) begin
            fill = ROW_DEPTH;
        end
        if (item.func == FUNC_INSERT) begin
            if (fill >= ROW_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                table_ofs[r][fill] = val;
                fill++;
                res.status = STATUS_DONE;
            end
        end else begin
            res.status = STATUS_NOT_FOUND;
            for (int i = 0; i < fill && !found; i++) begin
                if (table_ofs[r][i] == val) begin
                    fill--;
                    table_ofs[r][i] = table_ofs[r][fill];
                    res.status = STATUS_DONE;
                    found = 1'b1;
                end
            end
        end
        table_fill[r]  = FILL_W'(fill);
        res.fill_after = FILL_W'(fill);
        return res;
    endfunction

    // Drive one beat, hold it until accepted, then queue its expected result.
    task automatic send_beat(input bot_in_t item, input bit typed, input bot_out_t typed_res);
        bot_out_t pred;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        pred = apply_table_op(item);
        expected_results.push_back(typed ? typed_res : pred);
    endtask

    // Sender bursts: drop valid for a random gap once the burst runs out.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    always @(negedge aclk) begin
        if (rx_phase_left == 0) begin
            rx_mode       = rx_mode_t'($urandom_range(0, 3));
            rx_phase_left = $urandom_range(20, 300);
        end
        rx_phase_left--;
        rx_count++;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_ready <= (rx_count % 7 == 0);
            default:   m_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge aclk) begin : result_check
        bot_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, actual status %0d fill %0d",
                         $time, m_data.status, m_data.fill_after);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_data.status);
                    errors++;
                end
                if (m_data.fill_after !== want.fill_after) begin
                    $display("%0t: fill_after mismatch, expected %0d, actual %0d",
                             $time, want.fill_after, m_data.fill_after);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        bot_in_t                item;
        bot_out_t               typed_res;
        logic [ROW_FIELD_W-1:0] hot_rows [NUM_HOT_ROWS];
        logic [OFS_FIELD_W-1:0] ofs_pool [POOL_SIZE];
        int                     ins_pct;
        int                     r;

        for (int i = 0; i < NUM_ROWS; i++) begin
            table_fill[i] = '0;
        end

        dir_steps = '{
            // empty table, extremes of row and offset
            '{FUNC_INSERT, 10'd0,    32'h0000_0000, 1,  1'b1, STATUS_DONE,      5'd1},
            '{FUNC_REMOVE, 10'd0,    32'h0000_0000, 1,  1'b1, STATUS_DONE,      5'd0},
            '{FUNC_REMOVE, 10'd0,    32'h0000_0000, 1,  1'b1, STATUS_NOT_FOUND, 5'd0},
            '{FUNC_REMOVE, 10'd1023, 32'hFFFF_FFFF, 1,  1'b1, STATUS_NOT_FOUND, 5'd0},
            // duplicates: remove takes only the first match
            '{FUNC_INSERT, 10'd1023, 32'hFFFF_FFFF, 1,  1'b1, STATUS_DONE,      5'd1},
            '{FUNC_INSERT, 10'd1023, 32'hFFFF_FFFF, 1,  1'b1, STATUS_DONE,      5'd2},
            '{FUNC_REMOVE, 10'd1023, 32'hFFFF_FFFF, 1,  1'b1, STATUS_DONE,      5'd1},
            '{FUNC_REMOVE, 10'd1023, 32'hFFFF_FFFF, 1,  1'b1, STATUS_DONE,      5'd0},
            // fill a row to the top, then overflow it
            '{FUNC_INSERT, 10'd5,    32'hA5A5_0000, 16, 1'b0, STATUS_DONE,      5'd0},
            '{FUNC_INSERT, 10'd5,    32'h0000_0000, 1,  1'b1, STATUS_FULL,      5'd16},
            // middle, first, then the moved last entry
            '{FUNC_REMOVE, 10'd5,    32'hA5A5_0007, 1,  1'b1, STATUS_DONE,      5'd15},
            '{FUNC_REMOVE, 10'd5,    32'hA5A5_0000, 1,  1'b1, STATUS_DONE,      5'd14},
            '{FUNC_REMOVE, 10'd5,    32'hA5A5_000F, 1,  1'b0, STATUS_DONE,      5'd0},
            '{FUNC_REMOVE, 10'd5,    32'h1234_5678, 1,  1'b1, STATUS_NOT_FOUND, 5'd13},
            '{FUNC_INSERT, 10'd5,    32'h5555_5555, 1,  1'b0, STATUS_DONE,      5'd0},
            // alternating bit patterns
            '{FUNC_INSERT, 10'd682,  32'hAAAA_AAAA, 1,  1'b1, STATUS_DONE,      5'd1},
            '{FUNC_INSERT, 10'd341,  32'h5555_5555, 1,  1'b1, STATUS_DONE,      5'd1},
            '{FUNC_REMOVE, 10'd682,  32'h5555_5555, 1,  1'b1, STATUS_NOT_FOUND, 5'd1}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        burst_left = $urandom_range(1, 40);

        foreach (dir_steps[s]) begin
            for (int k = 0; k < dir_steps[s].reps; k++) begin
                item.func            = dir_steps[s].func;
                item.row             = dir_steps[s].row;
                item.offset          = dir_steps[s].offset + OFS_FIELD_W'(k);
                typed_res.status     = dir_steps[s].status;
                typed_res.fill_after = dir_steps[s].fill;
                send_beat(item, dir_steps[s].typed, typed_res);
                pace_sender();
            end
        end

        // Concentrate traffic on a few rows so they fill, overflow and drain.
        foreach (hot_rows[i]) begin
            hot_rows[i] = $urandom_range(0, NUM_ROWS - 1);
        end
        foreach (ofs_pool[i]) begin
            ofs_pool[i] = $urandom;
        end
        ofs_pool[0] = '0;
        ofs_pool[1] = '1;
        ins_pct = 50;
        typed_res = '0;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       ins_pct = 30;
                    1:       ins_pct = 50;
                    default: ins_pct = 70;
                endcase
            end
            if ($urandom_range(0, 99) < 85) begin
                r = hot_rows[$urandom_range(0, NUM_HOT_ROWS - 1)];
            end else begin
                r = $urandom_range(0, NUM_ROWS - 1);
            end
            item.row  = ROW_FIELD_W'(r);
            item.func = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
            if (item.func == FUNC_REMOVE && table_fill[r] != 0 && $urandom_range(0, 99) < 65) begin
                item.offset = OFS_FIELD_W'(table_ofs[r][$urandom_range(0, table_fill[r] - 1)]);
            end else if ($urandom_range(0, 1) == 1) begin
                item.offset = ofs_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                item.offset = $urandom;
            end
            send_beat(item, 1'b0, typed_res);
            pace_sender();
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
